/* rtl/core/nta_pkg.sv */
// Shared types, widths and register codes for the nearest texel address unit.
package nta_pkg;

  // Texture limits
  localparam int MAX_DIMS  = 3;
  localparam int MAX_SIZE  = 1024;

  // Field widths
  localparam int COORD_W   = 24;
  localparam int FRAC_W    = 16;
  localparam int DIM_W     = 2;
  localparam int CFG_SIZE_W = 11;
  localparam int INDEX_W   = 30;
  localparam int ADDR_W    = 32;
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 5;

  // Pipeline depth, one load enable per stage in nta_pipe_ld_t
  localparam int STAGES    = 6;

  // Derived datapath widths
  localparam int T_W       = $clog2(MAX_SIZE);          // texel coordinate, 0..size-1
  localparam int SIZE_W    = T_W + 1;                   // effective size, 1..MAX_SIZE
  localparam int QUO_W     = COORD_W - FRAC_W;          // quotient bits of t / size
  localparam int PROD_W    = COORD_W + T_W;             // coord * (size-1) + half
  localparam int TRAW_W    = PROD_W - FRAC_W;           // rounded texel coordinate
  localparam int MID_W     = T_W + QUO_W / 2;           // remainder after upper steps
  localparam int ROW_W     = 2 * T_W;                   // t_y + size_y * t_z
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_W - 1);

  // Register map
  typedef enum logic [2:0] {
    REG_DIM_COUNT    = 3'd0,
    REG_SIZE_X       = 3'd1,
    REG_SIZE_Y       = 3'd2,
    REG_SIZE_Z       = 3'd3,
    REG_WRAP_MODE    = 3'd4,
    REG_TEXTURE_BASE = 3'd5
  } nta_reg_t;

  // Wrap mode codes
  localparam logic WRAP_CLAMP  = 1'b0;
  localparam logic WRAP_REPEAT = 1'b1;

  // Per-lane addressing setup
  typedef struct packed {
    logic              active;
    logic              wrap;
    logic [SIZE_W-1:0] size;
    logic [T_W-1:0]    size_m1;
  } nta_lane_cfg_t;

  // Effective configuration seen by the datapath
  typedef struct packed {
    nta_lane_cfg_t     lane_x;
    nta_lane_cfg_t     lane_y;
    nta_lane_cfg_t     lane_z;
    logic [ADDR_W-1:0] base;
  } nta_cfg_t;

  // Stage load enables, stage 1 takes the input beat, stage 6 is the output
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } nta_pipe_ld_t;

  // Map a raw size register to 1..MAX_SIZE
  function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_SIZE_W-1:0] raw);
    logic [SIZE_W-1:0] s;
    if (raw == '0) begin
      s = SIZE_W'(1);
    end else if (raw > CFG_SIZE_W'(MAX_SIZE)) begin
      s = SIZE_W'(MAX_SIZE);
    end else begin
      s = SIZE_W'(raw);
    end
    return s;
  endfunction

endpackage

/* rtl/core/nearest_texel_address_unit.sv */
// Top level of the nearest texel address unit: registers, three lanes, merge and flow control.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+------------------------------------
//   in_      | in        | in_valid / in_ready       | coord_x, coord_y, coord_z (24b each)
//   out_     | out       | out_valid / out_ready     | texel_index (30b), texel_address (32b)
//   cfg_     | in        | psel/penable, pready = 1  | 6 registers at 4*i, 32-bit data
//
// Six-stage pipeline, one beat per cycle while out_ready keeps the last stage moving:
// one multiply stage and two modulo stages in each lane, then two multiply stages and an
// address stage in the merge. Each stage holds its beat while the one after it is full and
// stalled, so bubbles close up and in_ready stays high while any stage is empty.
// Synchronous reset empties the pipeline and loads the register defaults.
module nearest_texel_address_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [nta_pkg::COORD_W-1:0] in_coord_x,
  input  logic [nta_pkg::COORD_W-1:0] in_coord_y,
  input  logic [nta_pkg::COORD_W-1:0] in_coord_z,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [nta_pkg::INDEX_W-1:0] out_texel_index,
  output logic [nta_pkg::ADDR_W-1:0]  out_texel_address,
  // configuration port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [nta_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [nta_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [nta_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import nta_pkg::*;

  nta_cfg_t           cfg;
  nta_pipe_ld_t       ld;
  logic [STAGES-1:0]  vld_r;
  logic [STAGES-1:0]  vld_nxt;
  logic [STAGES-1:0]  en;
  logic [T_W-1:0]     t_x;
  logic [T_W-1:0]     t_y;
  logic [T_W-1:0]     t_z;

  assign cfg_pready = 1'b1;

  nta_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // Stage k may load when empty or when its beat moves on; last stage frees on out_ready
  always_comb begin
    en[STAGES-1] = !vld_r[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  // Advance the valid bits
  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < STAGES; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ld.s1 = en[0];
  assign ld.s2 = en[1];
  assign ld.s3 = en[2];
  assign ld.s4 = en[3];
  assign ld.s5 = en[4];
  assign ld.s6 = en[5];

  assign in_ready  = en[0];
  assign out_valid = vld_r[STAGES-1];

  nta_lane u_lane_x (
    .clk   (clk),
    .cfg   (cfg.lane_x),
    .ld    (ld),
    .coord (in_coord_x),
    .texel (t_x)
  );

  nta_lane u_lane_y (
    .clk   (clk),
    .cfg   (cfg.lane_y),
    .ld    (ld),
    .coord (in_coord_y),
    .texel (t_y)
  );

  nta_lane u_lane_z (
    .clk   (clk),
    .cfg   (cfg.lane_z),
    .ld    (ld),
    .coord (in_coord_z),
    .texel (t_z)
  );

  nta_merge u_merge (
    .clk           (clk),
    .cfg           (cfg),
    .ld            (ld),
    .t_x           (t_x),
    .t_y           (t_y),
    .t_z           (t_z),
    .texel_index   (out_texel_index),
    .texel_address (out_texel_address)
  );

endmodule

/* rtl/core/nta_regs.sv */
// Configuration register file with APB-style access and effective setup decode.
module nta_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nta_pkg::PADDR_W-1:0] paddr,
  input  logic [nta_pkg::DATA_W-1:0]  pwdata,
  output logic [nta_pkg::DATA_W-1:0]  prdata,
  output nta_pkg::nta_cfg_t           cfg
);
  import nta_pkg::*;

  logic [DIM_W-1:0]      dim_count_r;
  logic [CFG_SIZE_W-1:0] size_x_r;
  logic [CFG_SIZE_W-1:0] size_y_r;
  logic [CFG_SIZE_W-1:0] size_z_r;
  logic                  wrap_mode_r;
  logic [ADDR_W-1:0]     base_r;
  nta_reg_t              reg_sel;
  logic                  wr_en;
  logic [DIM_W-1:0]      dims;
  logic [SIZE_W-1:0]     sx;
  logic [SIZE_W-1:0]     sy;
  logic [SIZE_W-1:0]     sz;

  assign reg_sel = nta_reg_t'(paddr[PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;

  // Write the addressed register, ignore addresses past the map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_count_r <= DIM_W'(2);
      size_x_r    <= CFG_SIZE_W'(1);
      size_y_r    <= CFG_SIZE_W'(1);
      size_z_r    <= CFG_SIZE_W'(1);
      wrap_mode_r <= WRAP_CLAMP;
      base_r      <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_DIM_COUNT:    dim_count_r <= pwdata[DIM_W-1:0];
        REG_SIZE_X:       size_x_r    <= pwdata[CFG_SIZE_W-1:0];
        REG_SIZE_Y:       size_y_r    <= pwdata[CFG_SIZE_W-1:0];
        REG_SIZE_Z:       size_z_r    <= pwdata[CFG_SIZE_W-1:0];
        REG_WRAP_MODE:    wrap_mode_r <= pwdata[0];
        REG_TEXTURE_BASE: base_r      <= pwdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the raw register values
  always_comb begin
    unique case (reg_sel)
      REG_DIM_COUNT:    prdata = DATA_W'(dim_count_r);
      REG_SIZE_X:       prdata = DATA_W'(size_x_r);
      REG_SIZE_Y:       prdata = DATA_W'(size_y_r);
      REG_SIZE_Z:       prdata = DATA_W'(size_z_r);
      REG_WRAP_MODE:    prdata = DATA_W'(wrap_mode_r);
      REG_TEXTURE_BASE: prdata = DATA_W'(base_r);
      default:          prdata = '0;
    endcase
  end

  // Saturate dimension count to 1..MAX_DIMS
  always_comb begin
    if (dim_count_r == '0) begin
      dims = DIM_W'(1);
    end else if (dim_count_r > DIM_W'(MAX_DIMS)) begin
      dims = DIM_W'(MAX_DIMS);
    end else begin
      dims = dim_count_r;
    end
  end

  assign sx = eff_size(size_x_r);
  assign sy = eff_size(size_y_r);
  assign sz = eff_size(size_z_r);

  // Build the per-lane setup
  always_comb begin
    cfg.lane_x.active  = 1'b1;
    cfg.lane_x.wrap    = wrap_mode_r;
    cfg.lane_x.size    = sx;
    cfg.lane_x.size_m1 = T_W'(sx - SIZE_W'(1));
    cfg.lane_y.active  = (dims >= DIM_W'(2));
    cfg.lane_y.wrap    = wrap_mode_r;
    cfg.lane_y.size    = sy;
    cfg.lane_y.size_m1 = T_W'(sy - SIZE_W'(1));
    cfg.lane_z.active  = (dims >= DIM_W'(3));
    cfg.lane_z.wrap    = wrap_mode_r;
    cfg.lane_z.size    = sz;
    cfg.lane_z.size_m1 = T_W'(sz - SIZE_W'(1));
    cfg.base           = base_r;
  end

endmodule

/* rtl/core/nta_lane.sv */
// One coordinate lane: scale and round, then clamp or modulo over two stages.
module nta_lane (
  input  logic                         clk,
  input  nta_pkg::nta_lane_cfg_t       cfg,
  input  nta_pkg::nta_pipe_ld_t        ld,
  input  logic [nta_pkg::COORD_W-1:0]  coord,
  output logic [nta_pkg::T_W-1:0]      texel
);
  import nta_pkg::*;

  logic [PROD_W-1:0] prod_sum;
  logic [TRAW_W-1:0] traw_nxt;
  logic [TRAW_W-1:0] traw_r;
  logic [TRAW_W-1:0] rem_hi;
  logic [TRAW_W-1:0] div_hi;
  logic [T_W-1:0]    clamp_val;
  logic [MID_W-1:0]  mid_nxt;
  logic [MID_W-1:0]  mid_r;
  logic [MID_W-1:0]  rem_lo;
  logic [MID_W-1:0]  div_lo;
  logic [T_W-1:0]    texel_nxt;
  logic [T_W-1:0]    texel_r;

  // Stage 1: round-half-up of coord * (size-1), zero for an unused dimension
  always_comb begin
    prod_sum = PROD_W'(coord) * PROD_W'(cfg.size_m1) + HALF;
    traw_nxt = cfg.active ? prod_sum[PROD_W-1:FRAC_W] : '0;
  end

  // Stage 2: upper restoring steps of the modulo, or clamp to the edge
  always_comb begin
    rem_hi = traw_r;
    div_hi = '0;
    for (int k = QUO_W - 1; k >= QUO_W / 2; k--) begin
      div_hi = TRAW_W'(cfg.size) << k;
      if (rem_hi >= div_hi) begin
        rem_hi = rem_hi - div_hi;
      end
    end
    clamp_val = (traw_r > TRAW_W'(cfg.size_m1)) ? cfg.size_m1 : traw_r[T_W-1:0];
    mid_nxt   = (cfg.wrap == WRAP_REPEAT) ? rem_hi[MID_W-1:0] : MID_W'(clamp_val);
  end

  // Stage 3: lower restoring steps, remainder now below size
  always_comb begin
    rem_lo = mid_r;
    div_lo = '0;
    for (int k = QUO_W / 2 - 1; k >= 0; k--) begin
      div_lo = MID_W'(cfg.size) << k;
      if (rem_lo >= div_lo) begin
        rem_lo = rem_lo - div_lo;
      end
    end
    texel_nxt = (cfg.wrap == WRAP_REPEAT) ? rem_lo[T_W-1:0] : mid_r[T_W-1:0];
  end

  // Advance the lane registers on their stage loads
  always_ff @(posedge clk) begin
    if (ld.s1) begin
      traw_r <= traw_nxt;
    end
    if (ld.s2) begin
      mid_r <= mid_nxt;
    end
    if (ld.s3) begin
      texel_r <= texel_nxt;
    end
  end

  assign texel = texel_r;

endmodule

/* rtl/core/nta_merge.sv */
// Merge stage: mixed-radix texel index from the lane results, then word address.
module nta_merge (
  input  logic                         clk,
  input  nta_pkg::nta_cfg_t            cfg,
  input  nta_pkg::nta_pipe_ld_t        ld,
  input  logic [nta_pkg::T_W-1:0]      t_x,
  input  logic [nta_pkg::T_W-1:0]      t_y,
  input  logic [nta_pkg::T_W-1:0]      t_z,
  output logic [nta_pkg::INDEX_W-1:0]  texel_index,
  output logic [nta_pkg::ADDR_W-1:0]   texel_address
);
  import nta_pkg::*;

  logic [ROW_W-1:0]   row_nxt;
  logic [ROW_W-1:0]   row_r;
  logic [T_W-1:0]     tx_d_r;
  logic [INDEX_W-1:0] idx_nxt;
  logic [INDEX_W-1:0] idx_r;
  logic [INDEX_W-1:0] index_r;
  logic [ADDR_W-1:0]  addr_nxt;
  logic [ADDR_W-1:0]  addr_r;

  // Stage 4: inner radix term t_y + size_y * t_z
  assign row_nxt = ROW_W'(t_y) + ROW_W'(cfg.lane_y.size) * ROW_W'(t_z);

  // Stage 5: outer radix term t_x + size_x * row, kept to the index width
  assign idx_nxt = INDEX_W'(tx_d_r) + INDEX_W'(cfg.lane_x.size) * INDEX_W'(row_r);

  // Stage 6: word address, wraps at the address width
  assign addr_nxt = cfg.base + {idx_r, 2'b00};

  always_ff @(posedge clk) begin
    if (ld.s4) begin
      row_r  <= row_nxt;
      tx_d_r <= t_x;
    end
    if (ld.s5) begin
      idx_r <= idx_nxt;
    end
    if (ld.s6) begin
      index_r <= idx_r;
      addr_r  <= addr_nxt;
    end
  end

  assign texel_index   = index_r;
  assign texel_address = addr_r;

endmodule

/* test/testbench.sv */
// Self-checking testbench for the nearest texel address unit: directed table, random phases.
module testbench;

  import nta_pkg::*;

  // Run limits and timing
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 12;
  localparam int NUM_PHASES      = 16;
  localparam int BEATS_PER_PHASE = 103;
  localparam int PRESSURE_HOLD   = 300;
  localparam int REPORT_LIMIT    = 10;

  // Register slots past the end of the map, writes there must be dropped
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

  typedef struct packed {
    logic [INDEX_W-1:0] tex_index;
    logic [ADDR_W-1:0]  tex_addr;
  } texel_result_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [2:0]         reg_idx;
    logic [DATA_W-1:0]  value;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] cz;
    logic               known;
    texel_result_t      want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [COORD_W-1:0]  in_coord_x = '0;
  logic [COORD_W-1:0]  in_coord_y = '0;
  logic [COORD_W-1:0]  in_coord_z = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [INDEX_W-1:0]  out_texel_index;
  logic [ADDR_W-1:0]   out_texel_address;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0]  cfg_paddr = '0;
  logic [DATA_W-1:0]   cfg_pwdata = '0;
  logic [DATA_W-1:0]   cfg_prdata;
  logic                cfg_pready;

  // Shadow copy of the configuration registers
  logic [DIM_W-1:0]      mir_dims;
  logic [CFG_SIZE_W-1:0] mir_size_x;
  logic [CFG_SIZE_W-1:0] mir_size_y;
  logic [CFG_SIZE_W-1:0] mir_size_z;
  logic                  mir_wrap;
  logic [ADDR_W-1:0]     mir_base;

  texel_result_t pending_texels[$];
  stim_row_t     directed_rows[$];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int            pressure_requests = 0;
  int            pressure_served = 0;
  int            hold_left = 0;
  int            rx_span = 0;
  int            rx_tick = 0;
  rx_mode_t      rx_mode = RX_OPEN;

  nearest_texel_address_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_coord_x        (in_coord_x),
    .in_coord_y        (in_coord_y),
    .in_coord_z        (in_coord_z),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_texel_index   (out_texel_index),
    .out_texel_address (out_texel_address),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Count cycles and give up on a hang
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch at cycle %0d: %s expected 0x%08h got 0x%08h",
               cycle_count, what, want, got);
    end
  endtask

  // Round each coordinate to a texel, wrap or clamp it, then fold into a row-major index
  function automatic texel_result_t predict_texel(input logic [COORD_W-1:0] cx,
                                                  input logic [COORD_W-1:0] cy,
                                                  input logic [COORD_W-1:0] cz);
    logic [COORD_W-1:0]    coords [3];
    logic [CFG_SIZE_W-1:0] raw [3];
    logic [63:0]           size;
    logic [63:0]           t;
    logic [63:0]           acc;
    logic [63:0]           radix;
    int unsigned           dims;
    texel_result_t         r;
    coords[0] = cx;
    coords[1] = cy;
    coords[2] = cz;
    raw[0] = mir_size_x;
    raw[1] = mir_size_y;
    raw[2] = mir_size_z;
    dims = (mir_dims == '0) ? 1 : int'(mir_dims);
    if (dims > MAX_DIMS) dims = MAX_DIMS;
    acc = '0;
    radix = 64'd1;
    for (int d = 0; d < 3; d++) begin
      if (d < dims) begin
        if (raw[d] == '0) size = 64'd1;
        else if (raw[d] > CFG_SIZE_W'(MAX_SIZE)) size = 64'(MAX_SIZE);
        else size = 64'(raw[d]);
        t = (64'(coords[d]) * (size - 64'd1) + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
        if (mir_wrap == WRAP_REPEAT) t = t % size;
        else if (t > size - 64'd1) t = size - 64'd1;
        acc = acc + t * radix;
        radix = radix * size;
      end
    end
    r.tex_index = acc[INDEX_W-1:0];
    r.tex_addr  = mir_base + {r.tex_index, 2'b00};
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] reg_readback(input logic [2:0] idx);
    logic [DATA_W-1:0] v;
    v = '0;
    case (idx)
      REG_DIM_COUNT:    v = DATA_W'(mir_dims);
      REG_SIZE_X:       v = DATA_W'(mir_size_x);
      REG_SIZE_Y:       v = DATA_W'(mir_size_y);
      REG_SIZE_Z:       v = DATA_W'(mir_size_z);
      REG_WRAP_MODE:    v = DATA_W'(mir_wrap);
      REG_TEXTURE_BASE: v = mir_base;
      default:          v = '0;
    endcase
    return v;
  endfunction

  // One APB transfer, setup then access, then psel and penable drop back to idle
  task automatic cfg_access(input logic wr, input logic [2:0] idx,
                            input logic [DATA_W-1:0] val, output logic [DATA_W-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= PADDR_W'({idx, 2'b00});
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_check(input logic [2:0] idx);
    logic [DATA_W-1:0] rd;
    cfg_access(1'b0, idx, '0, rd);
    if (rd !== reg_readback(idx)) flag_mismatch("register readback", reg_readback(idx), rd);
  endtask

  // Write a register, track it in the shadow copy and read it back if it is in the map
  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] rd;
    cfg_access(1'b1, idx, val, rd);
    case (idx)
      REG_DIM_COUNT:    mir_dims   = val[DIM_W-1:0];
      REG_SIZE_X:       mir_size_x = val[CFG_SIZE_W-1:0];
      REG_SIZE_Y:       mir_size_y = val[CFG_SIZE_W-1:0];
      REG_SIZE_Z:       mir_size_z = val[CFG_SIZE_W-1:0];
      REG_WRAP_MODE:    mir_wrap   = val[0];
      REG_TEXTURE_BASE: mir_base   = val;
      default: ;
    endcase
    if (idx <= REG_TEXTURE_BASE) read_check(idx);
  endtask

  // Drop valid, let every result come back, then let the pipeline settle
  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_texels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Offer one beat and hold it until accepted, then record what it must produce
  task automatic send_beat(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                           input logic [COORD_W-1:0] cz, input logic known,
                           input texel_result_t want);
    in_valid   <= 1'b1;
    in_coord_x <= cx;
    in_coord_y <= cy;
    in_coord_z <= cz;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (known) pending_texels.insert(pending_texels.size(), want);
    else pending_texels.insert(pending_texels.size(), predict_texel(cx, cy, cz));
  endtask

  task automatic add_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    stim_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.reg_idx = idx;
    row.value = val;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic add_beat(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                          input logic [COORD_W-1:0] cz);
    stim_row_t row;
    row = '0;
    row.kind = ROW_BEAT;
    row.cx = cx;
    row.cy = cy;
    row.cz = cz;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic add_known(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                           input logic [COORD_W-1:0] cz, input logic [INDEX_W-1:0] ei,
                           input logic [ADDR_W-1:0] ea);
    stim_row_t row;
    row = '0;
    row.kind = ROW_BEAT;
    row.cx = cx;
    row.cy = cy;
    row.cz = cz;
    row.known = 1'b1;
    row.want.tex_index = ei;
    row.want.tex_addr = ea;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    logic [COORD_W-1:0] c;
    case ($urandom_range(0, 5))
      0, 1: c = COORD_W'($urandom());
      2:    c = COORD_W'($urandom_range(0, 'h10000));
      3:    c = COORD_W'($urandom_range('h10000, 'h40000));
      4: begin
        case ($urandom_range(0, 4))
          0:       c = '0;
          1:       c = '1;
          2:       c = COORD_W'('h10000);
          3:       c = COORD_W'('h8000);
          default: c = COORD_W'('hFFFF);
        endcase
      end
      default: c = COORD_W'($urandom_range(0, 'h1FFFF));
    endcase
    return c;
  endfunction

  // Size register value, upper bits filled with junk that the block must drop
  function automatic logic [DATA_W-1:0] rand_size_word();
    logic [DATA_W-1:0] w;
    logic [CFG_SIZE_W-1:0] s;
    case ($urandom_range(0, 7))
      0:       s = '0;
      1:       s = CFG_SIZE_W'(1);
      2:       s = CFG_SIZE_W'(2);
      3:       s = CFG_SIZE_W'(MAX_SIZE);
      4:       s = CFG_SIZE_W'($urandom_range(MAX_SIZE + 1, 2047));
      7:       s = CFG_SIZE_W'($urandom_range(1, MAX_SIZE));
      default: s = CFG_SIZE_W'($urandom_range(1, 16));
    endcase
    w = $urandom();
    w[CFG_SIZE_W-1:0] = s;
    return w;
  endfunction

  // Result side: stall on a changing pattern, with long hold-offs on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (pressure_served != pressure_requests) begin
      pressure_served = pressure_requests;
      hold_left = PRESSURE_HOLD;
      out_ready <= 1'b0;
    end else begin
      if (rx_span == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_span = $urandom_range(16, 160);
      end
      rx_span = rx_span - 1;
      rx_tick = rx_tick + 1;
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= (rx_tick % 3 != 0);
      endcase
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    texel_result_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_texels.size() == 0) begin
        flag_mismatch("result with nothing expected", '0, out_texel_address);
      end else begin
        want = pending_texels.pop_front();
        if (out_texel_index !== want.tex_index)
          flag_mismatch("texel_index", 32'(want.tex_index), 32'(out_texel_index));
        if (out_texel_address !== want.tex_addr)
          flag_mismatch("texel_address", want.tex_addr, out_texel_address);
      end
    end
  end

  initial begin : stimulus
    stim_row_t row;
    int sent;
    int burst;
    int gap;
    logic [DATA_W-1:0] word;

    // Hold reset, then load the shadow with the power-on values
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    mir_dims   = DIM_W'(2);
    mir_size_x = CFG_SIZE_W'(1);
    mir_size_y = CFG_SIZE_W'(1);
    mir_size_z = CFG_SIZE_W'(1);
    mir_wrap   = WRAP_CLAMP;
    mir_base   = '0;
    @(posedge clk);
    for (int i = REG_DIM_COUNT; i <= REG_TEXTURE_BASE; i++) read_check(3'(i));

    // Directed table: reset state, extremes, wrap modes and register corner cases
    add_known('0, '0, '0, '0, '0);
    add_known('1, '1, '1, '0, '0);
    add_write(REG_SIZE_X, DATA_W'(MAX_SIZE));
    add_write(REG_SIZE_Y, DATA_W'(MAX_SIZE));
    add_write(REG_SIZE_Z, DATA_W'(MAX_SIZE));
    add_write(REG_DIM_COUNT, DATA_W'(3));
    add_known('0, '0, '0, '0, '0);
    add_known('h10000, 'h10000, 'h10000, 30'h3FFFFFFF, 32'hFFFFFFFC);
    add_known('1, '1, '1, 30'h3FFFFFFF, 32'hFFFFFFFC);
    add_beat('h8000, 'h8000, 'h8000);
    add_beat('1, '0, 'h10000);
    add_write(REG_WRAP_MODE, DATA_W'(WRAP_REPEAT));
    add_beat('1, '1, '1);
    add_known('h10000, 'h10000, 'h10000, 30'h3FFFFFFF, 32'hFFFFFFFC);
    add_beat('h20000, '0, '0);
    add_write(REG_TEXTURE_BASE, 32'hFFFFFFFF);
    add_known('0, '0, '0, '0, 32'hFFFFFFFF);
    add_known('h10000, 'h10000, 'h10000, 30'h3FFFFFFF, 32'hFFFFFFFB);
    // Zero dimensions behaves as one, unused coordinates are ignored
    add_write(REG_DIM_COUNT, 32'hFFFFFFFC);
    add_known('h10000, '0, '0, 30'h3FF, 32'h00000FFB);
    add_known('0, '1, '1, '0, 32'hFFFFFFFF);
    // Size zero behaves as one, oversize saturates
    add_write(REG_SIZE_X, 32'hFFFFF800);
    add_known('h10000, '0, '0, '0, 32'hFFFFFFFF);
    add_write(REG_SIZE_X, DATA_W'(2047));
    add_known('h10000, '0, '0, 30'h3FF, 32'h00000FFB);
    add_write(REG_SPARE_6, '0);
    add_write(REG_SPARE_7, '1);
    add_beat('h8000, '0, '0);
    // Rounding at the half-texel point
    add_write(REG_DIM_COUNT, 32'hFFFFFFFD);
    add_write(REG_WRAP_MODE, DATA_W'(WRAP_CLAMP));
    add_write(REG_TEXTURE_BASE, 32'h00001000);
    add_write(REG_SIZE_X, DATA_W'(3));
    add_beat('h4000, '0, '0);
    add_beat('h3FFF, '0, '0);
    add_beat('1, '0, '0);
    // Mixed radix with odd sizes
    add_write(REG_DIM_COUNT, DATA_W'(2));
    add_write(REG_SIZE_X, DATA_W'(5));
    add_write(REG_SIZE_Y, DATA_W'(7));
    add_write(REG_WRAP_MODE, DATA_W'(WRAP_REPEAT));
    add_beat('hC000, 'h30000, '0);
    add_beat('1, '1, '1);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        settle_idle();
        write_reg(row.reg_idx, row.value);
      end else begin
        send_beat(row.cx, row.cy, row.cz, row.known, row.want);
      end
    end

    // Random phases, each under a fresh configuration
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle_idle();
      word = $urandom();
      word[DIM_W-1:0] = (ph < 4) ? DIM_W'(ph) : DIM_W'($urandom_range(0, 3));
      write_reg(REG_DIM_COUNT, word);
      if (ph == 0) begin
        write_reg(REG_SIZE_X, DATA_W'(MAX_SIZE));
        write_reg(REG_SIZE_Y, DATA_W'(MAX_SIZE));
        write_reg(REG_SIZE_Z, DATA_W'(MAX_SIZE));
      end else begin
        write_reg(REG_SIZE_X, rand_size_word());
        write_reg(REG_SIZE_Y, rand_size_word());
        write_reg(REG_SIZE_Z, rand_size_word());
      end
      word = $urandom();
      word[0] = (ph < 4) ? ph[0] : 1'($urandom_range(0, 1));
      write_reg(REG_WRAP_MODE, word);
      if (ph == 1) write_reg(REG_TEXTURE_BASE, '0);
      else if (ph == 2) write_reg(REG_TEXTURE_BASE, '1);
      else write_reg(REG_TEXTURE_BASE, $urandom());
      if (ph == 5) begin
        write_reg(REG_SPARE_6, $urandom());
        write_reg(REG_SPARE_7, $urandom());
      end
      // Stall the result side for a long stretch so the pipeline backs up
      if (ph == 2 || ph == 9) pressure_requests++;

      sent = 0;
      while (sent < BEATS_PER_PHASE) begin
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst && sent < BEATS_PER_PHASE; k++) begin
          send_beat(rand_coord(), rand_coord(), rand_coord(), 1'b0, '0);
          sent++;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    // Drain and decide
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_texels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_texels.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
